>>> hdl/lpht_pkg.sv
// Package for the linear-probe hash table: opcodes, status codes, slot marks,
// key/value widths and the request/response payload types. No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_DEL   = 2'd2;

    localparam logic [0:0] REG_HASH_MODULUS = 1'd0;
    localparam logic [0:0] REG_TABLE_LENGTH = 1'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [9:0]  slot_index;
    } rsp_t;

endpackage

>>> hdl/linear_probe_hash_table_top.sv
// Linear-probe hash table top level: sequencer, modulo unit, slot memories.
// Depends on lpht_pkg.
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_t
//  rsp      out        rsp_valid/stall    rsp_t
//  cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// The home slot is reduced from the 32-bit hash one remainder bit per cycle;
// each visited slot then takes a synchronous memory read, then a decide
// step, a write-back follows when a slot changes, and the response register
// is loaded last; the next transfer is taken once the sequencer is idle again.
// Reset clears marks through a sweep over all TABLE_DEPTH slots; no request is
// taken meanwhile. A stalled response holds in its register; a new response
// waits for it, and the request side stays stalled until the sequencer idles.
`timescale 1ns / 1ps
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [10:0] DEPTH11 = 11'(TABLE_DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_VALUE = 2'd1;
    localparam logic [1:0] WR_ENTRY = 2'd2;
    localparam logic [1:0] WR_MARK  = 2'd3;

    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
    logic [1:0]            mark_mem [TABLE_DEPTH];

    logic [10:0] hash_modulus_reg, table_length_reg;
    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [10:0] visit_reg, visit_next;
    logic [10:0] live_reg, live_next;
    logic [5:0]  bit_reg, bit_next;
    logic [11:0] rem_reg, rem_next;
    logic        free_ok_reg, free_ok_next;
    logic [AW-1:0] free_reg, free_next;
    req_t        req_reg;
    logic [2:0]  status_reg, status_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [1:0]  wr_kind_reg, wr_kind_next;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [1:0]            rd_mark;
    logic [VALUE_BITS-1:0] fval_reg, fval_next;

    logic [10:0] len_eff, mod_eff;
    logic [11:0] rem_shift;
    logic [12:0] live4, len3;
    logic        full_now, done_probe;
    logic [AW-1:0] idx_inc;

    always_comb
    begin
        len_eff = table_length_reg;
        if (len_eff == 11'd0)
            len_eff = 11'd1;
        if (len_eff > DEPTH11)
            len_eff = DEPTH11;
        mod_eff = hash_modulus_reg;
        if (mod_eff < 11'd2)
            mod_eff = 11'd2;
        if (mod_eff > len_eff)
            mod_eff = len_eff;
    end

    assign live4 = {live_reg, 2'b00};
    assign len3  = {2'b00, len_eff} + {1'b0, len_eff, 1'b0};
    assign full_now = live4 >= len3;
    assign rem_shift = {rem_reg[10:0], req_reg.key_hash[bit_reg[4:0]]};
    assign idx_inc = (11'(idx_reg) + 11'd1 == len_eff) ? '0 : idx_reg + AW'(1);

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_modulus_reg <= 11'd61;
            table_length_reg <= 11'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HASH_MODULUS: hash_modulus_reg <= cfg_data;
                REG_TABLE_LENGTH: table_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Memory read port: address is idx_reg during S_READ.
    always_ff @(posedge clk)
    begin
        rd_key  <= key_mem[idx_reg];
        rd_val  <= val_mem[idx_reg];
        rd_mark <= mark_mem[idx_reg];
    end

    // Write port: clear sweep or write-back.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mark_mem[idx_reg] <= MARK_EMPTY;
        else if (state_reg == S_WRITE)
        begin
            case (wr_kind_reg)
                WR_VALUE: val_mem[slot_reg] <= req_reg.value[VALUE_BITS-1:0];
                WR_ENTRY:
                begin
                    key_mem[slot_reg]  <= req_reg.key[KEY_BITS-1:0];
                    val_mem[slot_reg]  <= req_reg.value[VALUE_BITS-1:0];
                    mark_mem[slot_reg] <= MARK_LIVE;
                end
                WR_MARK: mark_mem[slot_reg] <= MARK_DEL;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        visit_next   = visit_reg;
        live_next    = live_reg;
        bit_next     = bit_reg;
        rem_next     = rem_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        wr_kind_next = wr_kind_reg;
        fval_next    = fval_reg;
        done_probe   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
                if (11'(idx_reg) == DEPTH11 - 11'd1)
                begin
                    idx_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next   = S_MOD;
                    bit_next     = 6'd31;
                    rem_next     = '0;
                    free_ok_next = 1'b0;
                    visit_next   = '0;
                    wr_kind_next = WR_NONE;
                    fval_next    = '0;
                    slot_next    = '0;
                    status_next  = ST_NOTFOUND;
                end
            end
            S_MOD:
            begin
                // one restoring-division step per cycle
                if (rem_shift >= {1'b0, mod_eff})
                    rem_next = rem_shift - {1'b0, mod_eff};
                else
                    rem_next = rem_shift;
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    idx_next = rem_next[AW-1:0];
                    state_next = S_READ;
                    if (req_reg.opcode == OP_INSERT)
                    begin
                        if (full_now)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                    end
                    else if (req_reg.opcode == OP_LOOKUP || req_reg.opcode == OP_DELETE)
                    begin
                        if (live_reg == 11'd0)
                            state_next = S_RESP;
                    end
                    else
                        state_next = S_RESP;
                end
            end
            S_READ:
                state_next = S_EVAL;
            S_EVAL:
            begin
                if (rd_mark == MARK_EMPTY)
                begin
                    done_probe = 1'b1;
                    if (req_reg.opcode == OP_INSERT && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx_reg;
                    end
                end
                else if (rd_mark == MARK_LIVE &&
                         rd_key == req_reg.key[KEY_BITS-1:0])
                begin
                    slot_next = idx_reg;
                    state_next = S_WRITE;
                    if (req_reg.opcode == OP_INSERT)
                    begin
                        status_next = ST_UPDATED;
                        wr_kind_next = WR_VALUE;
                    end
                    else if (req_reg.opcode == OP_LOOKUP)
                    begin
                        status_next = ST_FOUND;
                        fval_next = rd_val;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        status_next = ST_DELETED;
                        wr_kind_next = WR_MARK;
                        live_next = live_reg - 11'd1;
                    end
                end
                else
                begin
                    if (rd_mark == MARK_DEL && req_reg.opcode == OP_INSERT && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx_reg;
                    end
                    visit_next = visit_reg + 11'd1;
                    idx_next   = idx_inc;
                    if (visit_reg + 11'd1 == len_eff)
                        done_probe = 1'b1;
                    else
                        state_next = S_READ;
                end
                if (done_probe)
                begin
                    state_next = S_RESP;
                    if (req_reg.opcode == OP_INSERT)
                    begin
                        if (free_ok_next)
                        begin
                            status_next  = ST_INSERTED;
                            slot_next    = free_next;
                            wr_kind_next = WR_ENTRY;
                            live_next    = live_reg + 11'd1;
                            state_next   = S_WRITE;
                        end
                        else
                            status_next = ST_FULL;
                    end
                end
            end
            S_WRITE:
                state_next = S_RESP;
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            visit_reg     <= '0;
            bit_reg       <= '0;
            free_ok_reg   <= 1'b0;
            wr_kind_reg   <= WR_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            live_reg    <= live_next;
            visit_reg   <= visit_next;
            bit_reg     <= bit_next;
            free_ok_reg <= free_ok_next;
            wr_kind_reg <= wr_kind_next;
            if (state_reg == S_RESP && (!rsp_valid_reg || !rsp_stall))
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        free_reg   <= free_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        fval_reg   <= fval_next;
        if (state_reg == S_IDLE && req_valid)
            req_reg <= req;
        if (state_reg == S_RESP && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.found_value <= 32'(fval_reg);
            rsp_reg.slot_index  <= 10'(slot_reg);
        end
    end

endmodule

>>> hdl/lpht_checker.sv
// Port-level checker for the linear-probe hash table, bound to the top level.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_sva
    import lpht_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= ST_FULL)
        else $error("bad status code");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_FOUND |-> rsp.found_value == '0)
        else $error("value without found");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second transfer taken while busy");

endmodule

bind linear_probe_hash_table_top lpht_sva u_lpht_sva (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
);

>>> verif/lpht_checker.sv
// Checker for the linear-probe hash table: watches the request, response and
// config channels, predicts each response and compares. Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_checker
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          rsp_seen
);

    logic [31:0] mirror_keys [TABLE_DEPTH];
    logic [31:0] mirror_values [TABLE_DEPTH];
    logic [1:0]  mirror_marks [TABLE_DEPTH];
    int unsigned mirror_live;
    logic [10:0] modulus_reg;
    logic [10:0] length_reg;
    rsp_t        expected_rsps [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
        rsp_seen = 0;
        mirror_live = 0;
        modulus_reg = 11'd61;
        length_reg = 11'd64;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            mirror_marks[i] = MARK_EMPTY;
            mirror_keys[i] = '0;
            mirror_values[i] = '0;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] error: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic rsp_t table_access(input req_t r);
        rsp_t        o;
        int unsigned len;
        int unsigned md;
        int unsigned idx;
        int          free_slot;
        int          hit;
        len = (length_reg < 1) ? 1 : (length_reg > TABLE_DEPTH) ? TABLE_DEPTH : length_reg;
        md = (modulus_reg < 2) ? 2 : modulus_reg;
        if (md > len)
            md = len;
        idx = r.key_hash % md;
        o.status = ST_NOTFOUND;
        o.found_value = '0;
        o.slot_index = '0;
        free_slot = -1;
        hit = -1;
        if (r.opcode == OP_INSERT)
        begin
            if (4 * mirror_live >= 3 * len)
                o.status = ST_FULL;
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    if (mirror_marks[idx] == MARK_EMPTY)
                    begin
                        if (free_slot < 0)
                            free_slot = idx;
                        break;
                    end
                    if (mirror_marks[idx] == MARK_DEL)
                    begin
                        if (free_slot < 0)
                            free_slot = idx;
                    end
                    else if (mirror_keys[idx] == r.key)
                    begin
                        hit = idx;
                        break;
                    end
                    idx = (idx + 1 == len) ? 0 : idx + 1;
                end
                if (hit >= 0)
                begin
                    mirror_values[hit] = r.value;
                    o.status = ST_UPDATED;
                    o.slot_index = 10'(hit);
                end
                else if (free_slot >= 0)
                begin
                    mirror_keys[free_slot] = r.key;
                    mirror_values[free_slot] = r.value;
                    mirror_marks[free_slot] = MARK_LIVE;
                    mirror_live++;
                    o.status = ST_INSERTED;
                    o.slot_index = 10'(free_slot);
                end
                else
                    o.status = ST_FULL;
            end
        end
        else if ((r.opcode == OP_LOOKUP || r.opcode == OP_DELETE) && mirror_live != 0)
        begin
            for (int i = 0; i < len; i++)
            begin
                if (mirror_marks[idx] == MARK_EMPTY)
                    break;
                if (mirror_marks[idx] == MARK_LIVE && mirror_keys[idx] == r.key)
                begin
                    hit = idx;
                    break;
                end
                idx = (idx + 1 == len) ? 0 : idx + 1;
            end
            if (hit >= 0)
            begin
                o.slot_index = 10'(hit);
                if (r.opcode == OP_LOOKUP)
                begin
                    o.status = ST_FOUND;
                    o.found_value = mirror_values[hit];
                end
                else
                begin
                    mirror_marks[hit] = MARK_DEL;
                    mirror_live--;
                    o.status = ST_DELETED;
                end
            end
        end
        return o;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HASH_MODULUS)
                    modulus_reg = cfg_data;
                else
                    length_reg = cfg_data;
            end
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (expected_rsps.size() == 0)
                    report("response with none expected, status", 32'(rsp.status), 32'd0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                        report("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.found_value !== want.found_value)
                        report("found_value", rsp.found_value, want.found_value);
                    if (rsp.slot_index !== want.slot_index)
                        report("slot_index", 32'(rsp.slot_index), 32'(want.slot_index));
                end
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(table_access(req));
            pending = expected_rsps.size();
        end
    end

endmodule

>>> verif/tb_linear_probe_hash_table_top.sv
// Testbench top for the linear-probe hash table: drives requests, config
// writes and response stalls, and gives the verdict. Depends on lpht_pkg,
// lpht_checker and the block.
`timescale 1ns / 1ps
module tb_linear_probe_hash_table_top;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_HASH_MODULUS;
    logic [10:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          rsp_seen;
    int          cycle_count = 0;
    int          sent = 0;
    bit          hold_off = 1'b0;
    bit          drain_quiet = 1'b0;
    logic [31:0] key_pool [16];

    always #5 clk = ~clk;

    linear_probe_hash_table_top DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lpht_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // Receiver stalls at random, or holds off while asked to.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                rsp_stall <= 1'b1;
            else if (drain_quiet)
                rsp_stall <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                n = short_gap() + 1;
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Valid stays high across back-to-back sends; drop it only for a gap.
    task automatic send(input logic [1:0] op, input logic [31:0] k, input logic [31:0] h,
                        input logic [31:0] v, input bit gaps);
        int n;
        n = gaps ? short_gap() : 0;
        if ($urandom_range(0, 2) != 0)
            n = 0;
        if (n != 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{opcode: op, key: k, key_hash: h, value: v};
        do @(posedge clk); while (req_stall);
        sent++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait out all responses.
    task automatic settle();
        req_valid <= 1'b0;
        drain_quiet = 1'b1;
        while (pending != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        drain_quiet = 1'b0;
    endtask

    task automatic random_phase(input int count, input int pool_n);
        logic [1:0]  op;
        logic [31:0] k;
        int          sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, pool_n - 1);
            k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[sel];
            op = ($urandom_range(0, 9) < 4) ? OP_INSERT : 2'($urandom_range(1, 3));
            // Hash mostly follows the key so repeated keys share a home.
            send(op, k, ($urandom_range(0, 7) == 0) ? $urandom : k * 32'h9E37_79B1,
                 $urandom, 1'b1);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, every opcode, update and delete.
        send(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0);
        send(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send(OP_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send(OP_INSERT, 32'h5, 32'h0, 32'h1234_5678, 1'b0);
        send(OP_INSERT, 32'h5, 32'h0, 32'hAAAA_5555, 1'b0);
        send(OP_LOOKUP, 32'h5, 32'h0, 32'h0, 1'b0);
        send(OP_DELETE, 32'h0, 32'h0, 32'h0, 1'b0);
        send(OP_LOOKUP, 32'h5, 32'h0, 32'h0, 1'b0);
        send(OP_INSERT, 32'h5, 32'h0, 32'h5555_AAAA, 1'b0);
        send(OP_INSERT, 32'h7, 32'h0, 32'h7, 1'b0);
        send(OP_NONE, 32'h5, 32'h0, 32'h0, 1'b0);
        settle();

        // Tiny table: fill to full, then shrink it so the next insert is refused as full.
        write_reg(REG_TABLE_LENGTH, 11'd4);
        write_reg(REG_HASH_MODULUS, 11'd0);
        for (int i = 0; i < 6; i++)
            send(OP_INSERT, 32'h100 + 32'(i), 32'(i), 32'(i), 1'b0);
        send(OP_INSERT, 32'h100, 32'h0, 32'h99, 1'b0);
        send(OP_DELETE, 32'h100, 32'h0, 32'h0, 1'b0);
        send(OP_LOOKUP, 32'h101, 32'h1, 32'h0, 1'b0);
        settle();
        write_reg(REG_TABLE_LENGTH, 11'd2);
        send(OP_INSERT, 32'h200, 32'h1, 32'h1, 1'b0);
        send(OP_LOOKUP, 32'h200, 32'h1, 32'h1, 1'b0);
        settle();
        write_reg(REG_TABLE_LENGTH, 11'd0);
        write_reg(REG_HASH_MODULUS, 11'd2047);
        send(OP_INSERT, 32'h300, 32'hFFFF_FFFF, 32'h3, 1'b0);
        send(OP_LOOKUP, 32'h300, 32'h0, 32'h0, 1'b0);
        settle();

        // Receiver holds off while requests keep coming.
        write_reg(REG_TABLE_LENGTH, 11'd2047);
        write_reg(REG_HASH_MODULUS, 11'd61);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(20, 16);
        join
        settle();

        random_phase(250, 16);
        settle();
        write_reg(REG_TABLE_LENGTH, 11'd13);
        write_reg(REG_HASH_MODULUS, 11'd7);
        random_phase(150, 12);
        settle();
        write_reg(REG_TABLE_LENGTH, 11'd64);
        write_reg(REG_HASH_MODULUS, 11'd1);
        random_phase(130, 16);
        settle();
        write_reg(REG_HASH_MODULUS, 11'd31);
        random_phase(120, 16);
        settle();

        $display("covered %0d requests, %0d responses, across several table/modulus settings",
                 sent, rsp_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
